/* rtl/ngh_pkg.sv */
// Shared types and constants for the n-gram hash table.
// Holds table geometry, the hash multiplier, operation codes, FSM states
// and the command and status structs between controller and datapath.
package ngh_pkg;

  localparam int TABLE_SIZE = 4096;
  localparam int ADDR_W     = $clog2(TABLE_SIZE);
  localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
  localparam int MAX_USED   = TABLE_SIZE * 9 / 10;

  localparam int KEY_W   = 64;
  localparam int VAL_W   = 32;
  localparam int SLOT_W  = KEY_W + VAL_W;
  localparam int LEN_W   = 5;

  localparam logic [KEY_W-1:0] MULT_CONST = 64'd6364136223846793005;
  localparam logic [LEN_W-1:0] LEN_RESET  = 5'd4;
  localparam logic [LEN_W-1:0] LEN_MIN    = 5'd1;
  localparam logic [LEN_W-1:0] LEN_MAX    = 5'd16;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_GET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    S_INIT_CLR,
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_FOLD,
    S_DISPATCH,
    S_CLR_ADD,
    S_CLR_OP,
    S_PROBE_RD,
    S_PROBE_CMP
  } state_e;

  typedef struct packed {
    logic capture;
    logic mul_lo;
    logic mul_x1;
    logic mul_x2;
    logic fold;
    logic take_key;
    logic set_wr_flag;
    logic clr_begin;
    logic clr_write;
    logic probe_start;
    logic probe_rd;
    logic probe_next;
    logic ins_write;
    logic resp;
    logic resp_hit;
  } cmd_t;

  typedef struct packed {
    logic last;
    op_e  op;
    logic full;
    logic slot_empty;
    logic slot_match;
    logic clr_last;
  } status_t;

endpackage

/* rtl/ngh_ctrl.sv */
// Controller FSM for the n-gram hash table.
// Sequences hashing, clearing passes and probing; depends on ngh_pkg.
module ngh_ctrl import ngh_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_INIT_CLR: begin
        cmd_o.clr_write = 1'b1;
        if (status_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd_o.mul_lo = 1'b1;
        state_d = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul_x1 = 1'b1;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul_x2 = 1'b1;
        state_d = S_FOLD;
      end
      S_FOLD: begin
        cmd_o.fold = 1'b1;
        state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (!status_i.last) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.take_key = 1'b1;
          case (status_i.op)
            OP_ADD: begin
              if (status_i.full) begin
                cmd_o.set_wr_flag = 1'b1;
                cmd_o.clr_begin = 1'b1;
                state_d = S_CLR_ADD;
              end else begin
                state_d = S_PROBE_RD;
              end
            end
            OP_GET: begin
              state_d = S_PROBE_RD;
            end
            OP_CLEAR: begin
              cmd_o.clr_begin = 1'b1;
              state_d = S_CLR_OP;
            end
            default: begin
              cmd_o.resp = 1'b1;
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_CLR_ADD: begin
        cmd_o.clr_write = 1'b1;
        if (status_i.clr_last) begin
          cmd_o.probe_start = 1'b1;
          state_d = S_PROBE_RD;
        end
      end
      S_CLR_OP: begin
        cmd_o.clr_write = 1'b1;
        if (status_i.clr_last) begin
          cmd_o.resp = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_PROBE_RD: begin
        cmd_o.probe_rd = 1'b1;
        state_d = S_PROBE_CMP;
      end
      S_PROBE_CMP: begin
        if (status_i.op == OP_ADD) begin
          if (status_i.slot_empty || status_i.slot_match) begin
            cmd_o.ins_write = 1'b1;
            cmd_o.resp = 1'b1;
            state_d = S_IDLE;
          end else begin
            cmd_o.probe_next = 1'b1;
            state_d = S_PROBE_RD;
          end
        end else begin
          if (status_i.slot_match) begin
            cmd_o.resp = 1'b1;
            cmd_o.resp_hit = 1'b1;
            state_d = S_IDLE;
          end else if (status_i.slot_empty) begin
            cmd_o.resp = 1'b1;
            state_d = S_IDLE;
          end else begin
            cmd_o.probe_next = 1'b1;
            state_d = S_PROBE_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

/* rtl/ngh_datapath.sv */
// Datapath for the n-gram hash table: hash accumulator with a shared
// 32x32 multiplier, slot memory, probe address, occupancy count and results.
// Depends on ngh_pkg; driven by ngh_ctrl commands.
module ngh_datapath import ngh_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output status_t                 status_o,
  input  logic [1:0]              operation_i,
  input  logic signed [VAL_W-1:0] token_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic                    cfg_we_i,
  input  logic [LEN_W-1:0]        cfg_wdata_i,
  output logic                    done_o,
  output logic                    hit_o,
  output logic signed [VAL_W-1:0] found_value_o,
  output logic                    table_was_reset_o,
  output logic [CNT_W-1:0]        used_count_o
);

  logic [LEN_W-1:0]  len_q;
  logic [KEY_W-1:0]  acc_q;
  logic [LEN_W-1:0]  seen_q;
  logic              last_q;
  op_e               op_q;
  logic [VAL_W-1:0]  tok_q;
  logic [VAL_W-1:0]  val_q;
  logic [KEY_W-1:0]  lo_q;
  logic [31:0]       cross_q;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [ADDR_W-1:0] addr_q;
  logic [CNT_W-1:0]  used_q, used_d;
  logic              wr_flag_q;
  logic [SLOT_W-1:0] mem_q [TABLE_SIZE];
  logic [SLOT_W-1:0] rd_q;

  logic              done_q;
  logic              hit_q;
  logic [VAL_W-1:0]  found_q;
  logic              wrst_q;
  logic [CNT_W-1:0]  used_out_q;

  logic [31:0]       mul_a, mul_b;
  logic [KEY_W-1:0]  mul_p;
  logic [KEY_W-1:0]  fold_sum;
  logic [LEN_W-1:0]  seen_inc, eff_len;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_wd;
  logic [KEY_W-1:0]  slot_key;

  assign mul_a = cmd_i.mul_x2 ? acc_q[63:32] : acc_q[31:0];
  assign mul_b = cmd_i.mul_x1 ? MULT_CONST[63:32] : MULT_CONST[31:0];
  assign mul_p = mul_a * mul_b;

  assign fold_sum = {lo_q[63:32] + cross_q, lo_q[31:0]} + {{32{tok_q[31]}}, tok_q};
  assign seen_inc = seen_q + LEN_W'(1);
  assign eff_len  = (len_q < LEN_MIN) ? LEN_MIN : ((len_q > LEN_MAX) ? LEN_MAX : len_q);
  assign key_d    = (acc_q == '0) ? KEY_W'(1) : acc_q;

  assign mem_we   = cmd_i.clr_write | cmd_i.ins_write;
  assign mem_wd   = cmd_i.ins_write ? {key_q, val_q} : '0;
  assign slot_key = rd_q[SLOT_W-1:VAL_W];

  always_comb begin
    used_d = used_q;
    if (cmd_i.clr_begin) begin
      used_d = '0;
    end else if (cmd_i.ins_write && status_o.slot_empty) begin
      used_d = used_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= LEN_RESET;
      acc_q     <= '0;
      seen_q    <= '0;
      last_q    <= 1'b0;
      addr_q    <= '0;
      used_q    <= '0;
      wr_flag_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      if (cmd_i.fold) begin
        acc_q  <= fold_sum;
        last_q <= (seen_inc >= eff_len);
        seen_q <= (seen_inc >= eff_len) ? '0 : seen_inc;
      end else if (cmd_i.take_key) begin
        acc_q <= '0;
      end
      if (cmd_i.clr_begin) begin
        addr_q <= '0;
      end else if (cmd_i.probe_start) begin
        addr_q <= key_q[ADDR_W-1:0];
      end else if (cmd_i.take_key) begin
        addr_q <= key_d[ADDR_W-1:0];
      end else if (cmd_i.probe_next || cmd_i.clr_write) begin
        addr_q <= addr_q + ADDR_W'(1);
      end
      used_q <= used_d;
      if (cmd_i.set_wr_flag) begin
        wr_flag_q <= 1'b1;
      end else if (cmd_i.take_key) begin
        wr_flag_q <= 1'b0;
      end
      done_q <= cmd_i.resp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_e'(operation_i);
      tok_q <= token_i;
      val_q <= value_i;
    end
    if (cmd_i.mul_lo) begin
      lo_q <= mul_p;
    end
    if (cmd_i.mul_x1) begin
      cross_q <= mul_p[31:0];
    end else if (cmd_i.mul_x2) begin
      cross_q <= cross_q + mul_p[31:0];
    end
    if (cmd_i.take_key) begin
      key_q <= key_d;
    end
    if (cmd_i.resp) begin
      hit_q      <= cmd_i.resp_hit;
      found_q    <= cmd_i.resp_hit ? rd_q[VAL_W-1:0] : '1;
      wrst_q     <= wr_flag_q & ~cmd_i.take_key;
      used_out_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[addr_q] <= mem_wd;
    end
    if (cmd_i.probe_rd) begin
      rd_q <= mem_q[addr_q];
    end
  end

  assign status_o.last       = last_q;
  assign status_o.op         = op_q;
  assign status_o.full       = (used_q >= CNT_W'(MAX_USED));
  assign status_o.slot_empty = (slot_key == '0);
  assign status_o.slot_match = (slot_key == key_q);
  assign status_o.clr_last   = (addr_q == '1);

  assign done_o            = done_q;
  assign hit_o             = hit_q;
  assign found_value_o     = found_q;
  assign table_was_reset_o = wrst_q;
  assign used_count_o      = used_out_q;

  a_hit_only_get: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.resp && cmd_i.resp_hit) |-> (op_q == OP_GET))
    else $error("hit reported for an operation other than get");

  a_key_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins_write |-> (key_q != '0))
    else $error("insert with the empty key");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(MAX_USED))
    else $error("occupancy above the refill threshold");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for two cycles");

endmodule

/* rtl/ngram_hash_table.sv */
// Top level of the n-gram hash table: controller plus datapath.
// Depends on ngh_pkg, ngh_ctrl and ngh_datapath.
//
// Usage: present one key token per request on token_i together with
// operation_i and value_i and raise start while busy is low; the request
// is taken at that edge. Every ngram_len-th token (ngram_len clamped to
// 1..16) ends a key and its operation (add, get, clear) is carried out.
// The result appears for exactly one cycle with done_o high; the receiver
// cannot stall it. A token that does not end a key keeps busy high
// through MUL0, MUL1, MUL2, FOLD and DISPATCH. A key-ending add or get then
// reads and compares one probed slot at a time (PROBE_RD, PROBE_CMP),
// and done_o follows in the next cycle. Clear, and an add that finds the
// table at its refill level, add a clearing pass over the slot memory.
// The hash update runs MUL0, MUL1, MUL2 and FOLD on one shared 32x32
// multiplier; probing uses the single read port. After reset the
// block runs a clearing pass with busy high; ngram_len resets to 4 and
// may be written through cfg_we_i at any time the block is idle.
module ngram_hash_table import ngh_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              operation_i,
  input  logic signed [VAL_W-1:0] token_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic                    cfg_we_i,
  input  logic [LEN_W-1:0]        cfg_wdata_i,
  output logic                    done_o,
  output logic                    hit_o,
  output logic signed [VAL_W-1:0] found_value_o,
  output logic                    table_was_reset_o,
  output logic [CNT_W-1:0]        used_count_o
);

  cmd_t    cmd;
  status_t status;

  ngh_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  ngh_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .operation_i       (operation_i),
    .token_i           (token_i),
    .value_i           (value_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .done_o            (done_o),
    .hit_o             (hit_o),
    .found_value_o     (found_value_o),
    .table_was_reset_o (table_was_reset_o),
    .used_count_o      (used_count_o)
  );

endmodule

/* tb/tb_ngram_hash_table.sv */
// Self-checking testbench for ngram_hash_table: directed table, table fill, random keys.
// Predicts each result with its own hash-table model or a check row's fixed one; needs ngh_pkg and the RTL.
`timescale 1ns / 1ps

module tb_ngram_hash_table;
  import ngh_pkg::*;

  localparam int CLK_PERIOD = 8;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] found;
    logic             was_reset;
    logic [CNT_W-1:0] used;
  } lookup_t;

  typedef enum {ROW_REQ, ROW_CHK, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    logic [1:0]       op;
    logic [VAL_W-1:0] tok;
    logic [VAL_W-1:0] val;
    lookup_t          res;
  } step_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [1:0]              operation_i = OP_ADD;
  logic signed [VAL_W-1:0] token_i = '0;
  logic signed [VAL_W-1:0] value_i = '0;
  logic                    cfg_we_i = 1'b0;
  logic [LEN_W-1:0]        cfg_wdata_i = '0;
  logic                    done_o;
  logic                    hit_o;
  logic signed [VAL_W-1:0] found_value_o;
  logic                    table_was_reset_o;
  logic [CNT_W-1:0]        used_count_o;

  logic [KEY_W-1:0] slot_key [TABLE_SIZE];
  logic [VAL_W-1:0] slot_val [TABLE_SIZE];
  logic [KEY_W-1:0] hash_acc = '0;
  int               seen_cnt = 0;
  int               used_slots = 0;
  logic [LEN_W-1:0] cur_len = LEN_RESET;

  lookup_t     lookup_q [$];
  lookup_t     oldest;
  step_t       dir_steps [$];
  int          gap_pct = 0;
  int          fails = 0;
  int unsigned cycle_count = 0;

  ngram_hash_table DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .operation_i       (operation_i),
    .token_i           (token_i),
    .value_i           (value_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .done_o            (done_o),
    .hit_o             (hit_o),
    .found_value_o     (found_value_o),
    .table_was_reset_o (table_was_reset_o),
    .used_count_o      (used_count_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic int eff_len(logic [LEN_W-1:0] len);
    if (len < LEN_MIN) return LEN_MIN;
    if (len > LEN_MAX) return LEN_MAX;
    return len;
  endfunction

  function automatic logic [VAL_W-1:0] rand_token();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  function automatic lookup_t typed_miss(int u);
    lookup_t r;
    r.hit = 1'b0;
    r.found = '1;
    r.was_reset = 1'b0;
    r.used = u[CNT_W-1:0];
    return r;
  endfunction

  function automatic void row(row_kind_e kind, logic [1:0] op, logic [VAL_W-1:0] tok,
                              logic [VAL_W-1:0] val, lookup_t res = '0);
    step_t r;
    r.kind = kind;
    r.op = op;
    r.tok = tok;
    r.val = val;
    r.res = res;
    dir_steps.push_back(r);
  endfunction

  // Fold one token into the running hash; on the last token of a key, apply the operation.
  function automatic bit fold_token(input logic [1:0] op, input logic [VAL_W-1:0] tok,
                                    input logic [VAL_W-1:0] val, output lookup_t res);
    logic [KEY_W-1:0] key;
    int unsigned idx;
    int n;
    hash_acc = hash_acc * MULT_CONST + {{(KEY_W-VAL_W){tok[VAL_W-1]}}, tok};
    seen_cnt = (seen_cnt + 1) % 32;
    res = typed_miss(used_slots);
    if (seen_cnt < eff_len(cur_len)) return 1'b0;
    key = (hash_acc == '0) ? 64'd1 : hash_acc;
    hash_acc = '0;
    seen_cnt = 0;
    idx = 32'(key[ADDR_W-1:0]);
    n = 0;
    case (op)
      OP_ADD: begin
        if (used_slots >= MAX_USED) begin
          slot_key = '{default: '0};
          used_slots = 0;
          res.was_reset = 1'b1;
        end
        while (n < TABLE_SIZE && slot_key[idx] != '0 && slot_key[idx] != key) begin
          idx = (idx + 1) % TABLE_SIZE;
          n++;
        end
        if (slot_key[idx] == '0) used_slots++;
        slot_key[idx] = key;
        slot_val[idx] = val;
      end
      OP_GET: begin
        while (n < TABLE_SIZE && slot_key[idx] != '0 && slot_key[idx] != key) begin
          idx = (idx + 1) % TABLE_SIZE;
          n++;
        end
        if (slot_key[idx] == key) begin
          res.hit = 1'b1;
          res.found = slot_val[idx];
        end
      end
      OP_CLEAR: begin
        slot_key = '{default: '0};
        used_slots = 0;
      end
      default: ;
    endcase
    res.used = used_slots[CNT_W-1:0];
    return 1'b1;
  endfunction

  task automatic send_req(input logic [1:0] op, input logic [VAL_W-1:0] tok,
                          input logic [VAL_W-1:0] val, input bit typed = 1'b0,
                          input lookup_t typed_res = '0);
    lookup_t res;
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    start <= 1'b1;
    operation_i <= op;
    token_i <= tok;
    value_i <= val;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (fold_token(op, tok, val, res)) lookup_q.push_back(typed ? typed_res : res);
  endtask

  task automatic write_len(input logic [LEN_W-1:0] len);
    start <= 1'b0;
    while (lookup_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_len = len;
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ngram_hash_table verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (lookup_q.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result: hit %0d value %0d reset %0d used %0d",
                                  hit_o, found_value_o, table_was_reset_o, used_count_o);
      end else begin
        oldest = lookup_q.pop_front();
        if (hit_o !== oldest.hit || found_value_o !== oldest.found ||
            table_was_reset_o !== oldest.was_reset || used_count_o !== oldest.used) begin
          fails++;
          if (fails <= 10)
            $display("mismatch: expected hit %0d value %0d reset %0d used %0d, got %0d %0d %0d %0d",
                     oldest.hit, $signed(oldest.found), oldest.was_reset, oldest.used,
                     hit_o, found_value_o, table_was_reset_o, used_count_o);
        end
      end
    end
  end

  initial begin
    logic [VAL_W-1:0] key_pool [32][16];
    logic [VAL_W-1:0] recent [64];
    logic [VAL_W-1:0] tok;
    logic [1:0]       key_op;
    int               pick, eff, issued, r;

    slot_key = '{default: '0};
    slot_val = '{default: '0};
    foreach (key_pool[i, j]) key_pool[i][j] = rand_token();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // four-token key at the reset length, single-token keys for probing and wrap, then lengths 31 (clamped to 16) and 2
    row(ROW_REQ, OP_CLEAR, 32'h8000_0000, 32'd0);
    row(ROW_REQ, OP_GET,   32'h7FFF_FFFF, 32'd0);
    row(ROW_REQ, OP_NONE,  32'hFFFF_FFFF, 32'd0);
    row(ROW_CHK, OP_ADD,   32'd0,         32'h7FFF_FFFF, typed_miss(1));
    row(ROW_CFG, OP_NONE,  32'd1,         32'd0);
    row(ROW_CHK, OP_GET,   32'd5,         32'd0, typed_miss(1));
    row(ROW_CHK, OP_ADD,   32'd0,         32'h8000_0000, typed_miss(2));
    row(ROW_REQ, OP_GET,   32'd1,         32'd0);
    row(ROW_REQ, OP_ADD,   32'hFFFF_FFFF, 32'd7);
    row(ROW_REQ, OP_ADD,   32'd4095,      32'd8);
    row(ROW_REQ, OP_GET,   32'd4095,      32'd0);
    row(ROW_REQ, OP_ADD,   32'd4097,      32'd9);
    row(ROW_REQ, OP_ADD,   32'd4097,      32'hFFFF_FFFE);
    row(ROW_REQ, OP_GET,   32'd4097,      32'd0);
    row(ROW_REQ, OP_GET,   32'd8193,      32'd0);
    row(ROW_REQ, OP_NONE,  32'd3,         32'd5);
    row(ROW_CHK, OP_CLEAR, 32'd9,         32'd0, typed_miss(0));
    row(ROW_CHK, OP_GET,   32'd1,         32'd0, typed_miss(0));
    row(ROW_CFG, OP_NONE,  32'd0,         32'd0);
    row(ROW_REQ, OP_ADD,   32'h7FFF_FFFF, 32'd1);
    row(ROW_REQ, OP_GET,   32'h7FFF_FFFF, 32'd0);
    row(ROW_CFG, OP_NONE,  32'd31,        32'd0);
    row(ROW_REQ, OP_ADD,   32'd11,        32'd0);
    row(ROW_REQ, OP_GET,   32'd12,        32'd0);
    row(ROW_CFG, OP_NONE,  32'd2,         32'd0);
    row(ROW_REQ, OP_ADD,   32'd13,        32'd21);

    gap_pct = 30;
    foreach (dir_steps[i]) begin
      if (dir_steps[i].kind == ROW_CFG) write_len(dir_steps[i].tok[LEN_W-1:0]);
      else send_req(dir_steps[i].op, dir_steps[i].tok, dir_steps[i].val,
                    dir_steps[i].kind == ROW_CHK, dir_steps[i].res);
    end

    // fill past the refill level so that an add wipes the table
    gap_pct = 10;
    write_len(5'd1);
    send_req(OP_CLEAR, $urandom, $urandom);
    for (int i = 0; i < 3760; i++) begin
      if (i >= 64 && i % 64 == 0) begin
        send_req(OP_GET, recent[$urandom_range(63)], $urandom);
      end else begin
        tok = $urandom;
        recent[i % 64] = tok;
        send_req(OP_ADD, tok, rand_token());
      end
    end

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: write_len(5'd3);
        1: write_len(5'd16);
        2: write_len(5'd1);
        default: write_len($urandom_range(0, 31));
      endcase
      gap_pct = (p == 1) ? 55 : (p == 3) ? 15 : 0;
      issued = 0;
      while (issued < 500) begin
        eff = eff_len(cur_len);
        pick = ($urandom_range(99) < 75) ? $urandom_range(31) : -1;
        r = $urandom_range(99);
        key_op = (r < 45) ? OP_ADD : (r < 85) ? OP_GET : (r < 97) ? OP_NONE : OP_CLEAR;
        for (int t = 0; t < eff; t++) begin
          tok = (pick >= 0) ? key_pool[pick][t] : rand_token();
          send_req((t == eff - 1) ? key_op : 2'($urandom_range(3)), tok, rand_token());
        end
        issued += eff;
      end
      // send up to two stray tokens so that the next length change can land mid-key
      repeat ($urandom_range(0, 2)) send_req(2'($urandom_range(3)), rand_token(), $urandom);
    end

    start <= 1'b0;
    while (lookup_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fails == 0 && lookup_q.size() == 0) begin
      $display("ngram_hash_table verification clean");
    end else begin
      $display("ngram_hash_table verification failed");
    end
    $finish;
  end

endmodule
